[rtl/lruc_pkg.sv]
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared sizes, codes and control types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int AGE_W   = IDX_W;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ADDR_W  = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(16);
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = '0;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
  } lruc_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lruc_stat_t;

endpackage

[rtl/lruc_ctrl.sv]
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer: accept an item, run the entry scan, then commit the update and
// load the result register.
// ----------------------------------------------------------------------------
module lruc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lruc_pkg::lruc_stat_t stat,
  output lruc_pkg::lruc_cmd_t  cmd
);
  import lruc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_room;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_room  = !out_valid_r || !out_stall;

  always_comb begin
    cmd.start  = (state_r == ST_IDLE) && in_valid;
    cmd.scan   = (state_r == ST_SCAN);
    cmd.update = (state_r == ST_UPDATE) && out_room;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_room) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/lruc_dp.sv]
// ----------------------------------------------------------------------------
// lruc_dp
// Datapath: key and value memories, valid bits, age ranks, occupancy, the
// serial match/free/victim scan and the result register.
// ----------------------------------------------------------------------------
module lruc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_cmd,
  input  logic signed [lruc_pkg::DATA_W-1:0] in_lookup_key,
  input  logic signed [lruc_pkg::DATA_W-1:0] in_write_value,
  input  logic        [lruc_pkg::CAP_W-1:0]  capacity,
  input  lruc_pkg::lruc_cmd_t                cmd,
  output lruc_pkg::lruc_stat_t               stat,
  output logic                              out_hit,
  output logic signed [lruc_pkg::DATA_W-1:0] out_read_value,
  output logic                              out_evicted,
  output logic signed [lruc_pkg::DATA_W-1:0] out_evicted_key
);
  import lruc_pkg::*;

  logic [DATA_W-1:0] key_mem [ENTRIES];
  logic [DATA_W-1:0] val_mem [ENTRIES];
  logic [DATA_W-1:0] key_rd_r, val_rd_r;

  logic              valid_r [ENTRIES];
  logic              valid_nxt [ENTRIES];
  logic [AGE_W-1:0]  age_r [ENTRIES];
  logic [AGE_W-1:0]  age_nxt [ENTRIES];
  logic [CNT_W-1:0]  occ_r;

  logic              op_r;
  logic [DATA_W-1:0] key_r, val_r;

  logic [CNT_W-1:0]  cnt_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;

  logic              match_found_r, free_found_r, vic_found_r;
  logic [IDX_W-1:0]  match_idx_r, free_idx_r, vic_idx_r;
  logic [DATA_W-1:0] match_val_r, vic_key_r;
  logic [AGE_W-1:0]  vic_age_r;

  logic              hit_r, ev_r;
  logic [DATA_W-1:0] rdval_r, evkey_r;

  logic              cmp_valid;
  logic [AGE_W-1:0]  cmp_age;
  logic              is_match, is_free, is_vic;
  logic [IDX_W-1:0]  rd_addr;

  logic [CMP_W-1:0]  cap_x, ent_x, occ_x, eff_cap;
  logic              do_evict, do_insert, touch_en;
  logic [IDX_W-1:0]  slot;
  logic [AGE_W-1:0]  touch_age;
  logic              key_we, val_we;
  logic [IDX_W-1:0]  val_waddr;

  assign rd_addr        = cnt_r[IDX_W-1:0];
  assign stat.scan_done = (cnt_r == CNT_W'(ENTRIES)) && !cmp_vld_r;

  // scan compare for the entry read in the previous cycle
  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_age   = age_r[cmp_idx_r];
  assign is_match  = cmp_vld_r && cmp_valid && (key_rd_r == key_r) && !match_found_r;
  assign is_free   = cmp_vld_r && !cmp_valid && !free_found_r;
  assign is_vic    = cmp_vld_r && cmp_valid && (!vic_found_r || (cmp_age > vic_age_r));

  // update decisions
  assign cap_x   = CMP_W'(capacity);
  assign ent_x   = CMP_W'(ENTRIES);
  assign occ_x   = CMP_W'(occ_r);
  assign eff_cap = (cap_x == '0) ? CMP_W'(1) : ((cap_x > ent_x) ? ent_x : cap_x);

  assign touch_en  = match_found_r;
  assign touch_age = age_r[match_idx_r];
  assign do_evict  = (op_r == CMD_PUT) && !match_found_r && (occ_x >= eff_cap) &&
                     (occ_r != '0) && vic_found_r;
  assign do_insert = (op_r == CMD_PUT) && !match_found_r && (do_evict || free_found_r);

  always_comb begin
    if (do_evict && !(free_found_r && (free_idx_r < vic_idx_r))) begin
      slot = vic_idx_r;
    end else begin
      slot = free_idx_r;
    end
  end

  assign key_we    = cmd.update && do_insert;
  assign val_we    = cmd.update && (op_r == CMD_PUT) && (match_found_r || do_insert);
  assign val_waddr = match_found_r ? match_idx_r : slot;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      age_nxt[i]   = age_r[i];
      if (touch_en) begin
        if (IDX_W'(i) == match_idx_r) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_r[i] < touch_age)) begin
          age_nxt[i] = AGE_W'(age_r[i] + AGE_W'(1));
        end
      end else if (do_insert) begin
        if (do_evict && (IDX_W'(i) == vic_idx_r)) begin
          valid_nxt[i] = 1'b0;
          age_nxt[i]   = '0;
        end else if (valid_r[i]) begin
          age_nxt[i] = AGE_W'(age_r[i] + AGE_W'(1));
        end
        if (IDX_W'(i) == slot) begin
          valid_nxt[i] = 1'b1;
          age_nxt[i]   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
      occ_r <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        age_r[i]   <= age_nxt[i];
      end
      if (do_insert) occ_r <= CNT_W'(occ_r - CNT_W'(do_evict) + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[rd_addr];
    if (key_we) key_mem[slot] <= key_r;
  end

  always_ff @(posedge clk) begin
    val_rd_r <= val_mem[rd_addr];
    if (val_we) val_mem[val_waddr] <= val_r;
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      cmp_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (cmd.start) begin
      cnt_r         <= '0;
      cmp_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= (cnt_r != CNT_W'(ENTRIES));
      if (cnt_r != CNT_W'(ENTRIES)) cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
      if (is_match) match_found_r <= 1'b1;
      if (is_free)  free_found_r  <= 1'b1;
      if (is_vic)   vic_found_r   <= 1'b1;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_cmd;
      key_r <= in_lookup_key;
      val_r <= in_write_value;
    end
    if (cmd.scan) begin
      cmp_idx_r <= rd_addr;
      if (is_match) begin
        match_idx_r <= cmp_idx_r;
        match_val_r <= val_rd_r;
      end
      if (is_free) free_idx_r <= cmp_idx_r;
      if (is_vic) begin
        vic_idx_r <= cmp_idx_r;
        vic_age_r <= cmp_age;
        vic_key_r <= key_rd_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_r <= match_found_r;
      ev_r  <= do_evict;
      if (op_r == CMD_GET) begin
        rdval_r <= match_found_r ? match_val_r : MISS_VALUE;
      end else begin
        rdval_r <= '0;
      end
      evkey_r <= do_evict ? vic_key_r : '0;
    end
  end

  assign out_hit         = hit_r;
  assign out_read_value  = rdval_r;
  assign out_evicted     = ev_r;
  assign out_evicted_key = evkey_r;

endmodule

[rtl/lru_cache_key_value_top.sv]
// ----------------------------------------------------------------------------
// lru_cache_key_value_top
// Fully associative key-value cache with least-recently-used replacement.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   in_      | input     | in_valid/in_stall   | cmd, lookup_key, write_value
//   out_     | output    | out_valid/out_stall | hit, read_value, evicted,
//            |           |                     | evicted_key
//   APB      | input     | psel/penable/pready | capacity_in_use at address 0
//
// An item goes through one key memory read per entry, a last compare, an
// end-of-scan step and the update step; only then does the sequencer return
// to idle and take a new item, so one item is in flight at a time.
// Reset is synchronous; valid bits, ages and occupancy clear at once.
// A stalled result holds in the output register while the next item is taken;
// that item then waits in its update cycle until the result is taken.
// ----------------------------------------------------------------------------
module lru_cache_key_value_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic signed [lruc_pkg::DATA_W-1:0] in_lookup_key,
  input  logic signed [lruc_pkg::DATA_W-1:0] in_write_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic signed [lruc_pkg::DATA_W-1:0] out_read_value,
  output logic                               out_evicted,
  output logic signed [lruc_pkg::DATA_W-1:0] out_evicted_key,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [lruc_pkg::ADDR_W-1:0] paddr,
  input  logic        [lruc_pkg::DATA_W-1:0] pwdata,
  output logic        [lruc_pkg::DATA_W-1:0] prdata,
  output logic                               pready
);
  import lruc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  lruc_cmd_t        cmd;
  lruc_stat_t       stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lruc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_lookup_key   (in_lookup_key),
    .in_write_value  (in_write_value),
    .capacity        (cap_r),
    .cmd             (cmd),
    .stat            (stat),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

[rtl/lruc_chk.sv]
// ----------------------------------------------------------------------------
// lruc_chk
// Port-level checks for the LRU cache, bound to the top level.
// ----------------------------------------------------------------------------
module lruc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_hit,
  input logic signed [lruc_pkg::DATA_W-1:0] out_read_value,
  input logic                               out_evicted,
  input logic signed [lruc_pkg::DATA_W-1:0] out_evicted_key
);
  import lruc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_read_value) && $stable(out_evicted) && $stable(out_evicted_key))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid || !in_stall)
    else $error("result repeated after it was taken");

  a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && (out_read_value == '0))
    else $error("eviction reported on a hit or a get");

endmodule

bind lru_cache_key_value_top lruc_chk u_chk (.*);

[tb/sv/lruc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lruc_checker
// Watches the item, result and APB channels of the LRU key-value cache. It
// keeps its own copy of the store and of the capacity register, and works out
// the reply to every accepted item. Each accepted result is compared field by
// field with the oldest reply still owed. Capacity read-backs are checked too.
// ----------------------------------------------------------------------------
module lruc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [lruc_pkg::DATA_W-1:0] in_lookup_key,
  input  logic [lruc_pkg::DATA_W-1:0] in_write_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_hit,
  input  logic [lruc_pkg::DATA_W-1:0] out_read_value,
  input  logic                        out_evicted,
  input  logic [lruc_pkg::DATA_W-1:0] out_evicted_key,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lruc_pkg::ADDR_W-1:0] paddr,
  input  logic [lruc_pkg::DATA_W-1:0] pwdata,
  input  logic [lruc_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          pending,
  output int                          hits,
  output int                          evictions
);
  import lruc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } reply_t;

  reply_t            owed_replies[$];
  logic              ent_valid [ENTRIES];
  logic [DATA_W-1:0] ent_key   [ENTRIES];
  logic [DATA_W-1:0] ent_value [ENTRIES];
  int                ent_age   [ENTRIES];
  int                occupancy;
  logic [CAP_W-1:0]  capacity;

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  function automatic void promote(input int s);
    int a;
    a = ent_age[s];
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && i != s && ent_age[i] < a) ent_age[i]++;
    ent_age[s] = 0;
  endfunction

  function automatic reply_t cache_access(input logic cmd, input logic [DATA_W-1:0] key,
                                          input logic [DATA_W-1:0] val);
    reply_t r;
    int     slot;
    int     victim;
    int     cap_eff;
    r    = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && ent_valid[i] && ent_key[i] == key) slot = i;
    if (cmd == CMD_GET) begin
      if (slot >= 0) begin
        r.hit        = 1'b1;
        r.read_value = ent_value[slot];
        promote(slot);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (slot >= 0) begin
      r.hit           = 1'b1;
      ent_value[slot] = val;
      promote(slot);
    end else begin
      cap_eff = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
      if (occupancy >= cap_eff && occupancy > 0) begin
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && (victim < 0 || ent_age[i] > ent_age[victim])) victim = i;
        if (victim >= 0) begin
          r.evicted         = 1'b1;
          r.evicted_key     = ent_key[victim];
          ent_valid[victim] = 1'b0;
          ent_age[victim]   = 0;
          occupancy--;
        end
      end
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !ent_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (ent_valid[i]) ent_age[i]++;
        ent_valid[slot] = 1'b1;
        ent_key[slot]   = key;
        ent_value[slot] = val;
        ent_age[slot]   = 0;
        occupancy++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i] = 1'b0;
        ent_key[i]   = '0;
        ent_value[i] = '0;
        ent_age[i]   = 0;
      end
      occupancy = 0;
      capacity  = CAP_RESET;
      owed_replies.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_CAPACITY) begin
        if (pwrite) capacity = pwdata[CAP_W-1:0];
        else compare_field("prdata", DATA_W'(capacity), prdata);
      end
      if (out_valid && !out_stall) begin
        got = '{out_hit, out_read_value, out_evicted, out_evicted_key};
        if (owed_replies.size() == 0) begin
          $error("result with no item outstanding: hit %b value %h", out_hit, out_read_value);
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          compare_field("hit", DATA_W'(want.hit), DATA_W'(got.hit));
          compare_field("read_value", want.read_value, got.read_value);
          compare_field("evicted", DATA_W'(want.evicted), DATA_W'(got.evicted));
          compare_field("evicted_key", want.evicted_key, got.evicted_key);
        end
      end
      if (in_valid && !in_stall) begin
        want = cache_access(in_cmd, in_lookup_key, in_write_value);
        if (want.hit) hits++;
        if (want.evicted) evictions++;
        owed_replies.push_back(want);
      end
      pending <= owed_replies.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LRU key-value cache. A short directed run hits
// the key and value extremes, get and put on hit and miss, and capacities of
// zero, one, above the entry count and below the occupancy. Random phases
// then mix a small key pool with wild keys under several idling patterns,
// one long output hold-off, and a capacity change between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lruc_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 2 * (ENTRIES + 3);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [DATA_W-1:0] in_lookup_key;
  logic [DATA_W-1:0] in_write_value;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_value;
  logic              out_evicted;
  logic [DATA_W-1:0] out_evicted_key;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int hits;
  int evictions;
  int items_sent;
  int send_pct;
  int stall_pct;
  int holdoff_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_cache_key_value_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  lruc_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .pending        (pending),
    .hits           (hits),
    .evictions      (evictions)
  );

  initial begin : receiver
    int served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_lookup_key  <= key;
    in_write_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every owed result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_capacity(input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int n, input logic [DATA_W-1:0] cap, input int s_pct,
                           input int r_pct, input bit with_holdoff);
    logic [DATA_W-1:0] pool [ENTRIES+3];
    logic [DATA_W-1:0] key;
    int                pool_n;
    int                pick;
    settle();
    program_capacity(cap);
    send_pct = s_pct;
    stall_pct <= r_pct;
    pool_n = ((cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap))) + 3;
    foreach (pool[i]) pool[i] = $urandom();
    if (with_holdoff) holdoff_req <= holdoff_req + 1;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        key = pool[$urandom_range(pool_n - 1)];
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0:       key = '0;
          1:       key = '1;
          2:       key = 32'h8000_0000;
          default: key = 32'h7FFF_FFFF;
        endcase
      end else begin
        key = $urandom();
      end
      send_item($urandom_range(1) ? CMD_PUT : CMD_GET, key, $urandom());
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_cmd         <= CMD_GET;
    in_lookup_key  <= '0;
    in_write_value <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    stall_pct      <= 0;
    holdoff_req    <= 0;
    send_pct       = 0;
    items_sent     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0005);
    send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_3039, 32'hFFFF_FFFF);
    // drop capacity below the current occupancy
    settle();
    program_capacity(1);
    send_item(CMD_PUT, 32'h0000_0001, 32'h0000_0011);
    send_item(CMD_PUT, 32'h0000_0002, 32'h0000_0022);
    send_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    settle();
    program_capacity(0);
    send_item(CMD_PUT, 32'h0000_0003, 32'h0000_0033);
    send_item(CMD_PUT, 32'h0000_0003, 32'h0000_0044);
    send_item(CMD_GET, 32'h0000_0003, 32'h0000_0000);
    send_item(CMD_PUT, 32'h8000_0000, 32'h5555_AAAA);
    settle();
    program_capacity(31);
    send_item(CMD_PUT, 32'hAAAA_5555, 32'h0F0F_F0F0);
    send_item(CMD_PUT, 32'h5555_AAAA, 32'hF0F0_0F0F);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_0003, 32'h0000_0000);

    run_phase(200, 16,  0,  0, 1'b0);
    run_phase(200,  4, 58,  0, 1'b0);
    run_phase(150,  1,  0, 58, 1'b0);
    run_phase(100,  0, 26, 26, 1'b0);
    run_phase(150, 31, 26, 26, 1'b0);
    run_phase( 60, 16,  0,  0, 1'b1);
    run_phase(200,  8, 26, 26, 1'b0);
    run_phase(150, 17,  0,  0, 1'b0);
    run_phase(100,  2, 58,  0, 1'b0);
    run_phase(100, 12,  0, 58, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over capacities 0 to 31, with %0d hits and %0d evictions.",
             items_sent, hits, evictions);
    $display("Idling mixes: none, sender, receiver, both, plus one long output hold-off.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lruc_pkg.sv
rtl/lruc_ctrl.sv
rtl/lruc_dp.sv
rtl/lru_cache_key_value_top.sv
rtl/lruc_chk.sv
tb/sv/lruc_checker.sv
tb/sv/tb_top.sv
